// File: src/hcd_pkg.sv
`timescale 1ns / 1ps

package hcd_pkg;

   // Characters that steer the size line
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // One classified input beat
   typedef struct packed {
      logic [7:0] data;
      logic       is_lf;
      logic       is_cr;
      logic       is_blank;
      logic       is_hex;
      logic [3:0] hex_val;
   } beat_type;

   typedef struct packed {
      logic     valid;
      beat_type beat;
   } push_type;

   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic pop;
      logic done;
      logic enable;
   } back_status_type;

   // Decoding phase
   typedef enum logic [3:0] {
      PH_SIZE = 4'b0001,
      PH_DATA = 4'b0010,
      PH_CRLF = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   // Position on the size line
   typedef enum logic [2:0] {
      LM_LEAD = 3'b001,
      LM_HEX  = 3'b010,
      LM_REST = 3'b100
   } line_mode_type;

endpackage

// File: src/hcd_req_if.sv
`timescale 1ns / 1ps

interface hcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

// File: src/hcd_rsp_if.sv
`timescale 1ns / 1ps

interface hcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       stream_end;

   modport source (output valid, output out_byte, output stream_end, input ready);
   modport sink (input valid, input out_byte, input stream_end, output ready);
endinterface

// File: src/http_chunked_decoder.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Payload
// req      in   valid/ready    in_byte[7:0]
// rsp      out  valid/ready    out_byte[7:0], stream_end
// csr      in   csr_wr_en      csr_wr_data (chunked_enable)
//
// One beat per cycle sustained while rsp is ready; each beat updates the back's state as it is popped.
// An accepted beat is stored in the queue, then its result goes to the output register on rsp.
// A two-entry queue parts the front from the back; an output register parts the back from rsp.
// Reset is synchronous: decoding restarts on a size line and chunked mode is off.
// A stall on rsp holds the output register; req keeps accepting until the queue is full.

module http_chunked_decoder #(
   parameter int SIZE_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   hcd_req_if.sink   req,
   hcd_rsp_if.source rsp,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);
   import hcd_pkg::*;

   push_type         push;
   queue_status_type q_status;
   beat_type         head;
   logic             pop;
   back_status_type  b_status;

   hcd_front u_front (
      .req      (req),
      .q_status (q_status),
      .push     (push)
   );

   hcd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   hcd_back #(
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .head        (head),
      .pop         (pop),
      .status      (b_status),
      .rsp         (rsp)
   );

   // End marker carries a zero byte
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.stream_end |-> rsp.out_byte == 8'd0)
      else $error("stream end with nonzero byte");

   // An accepted beat lands in the queue
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> q_status.count != '0)
      else $error("accepted beat lost in queue");

   // Queue never exceeds its depth
   a_queue_depth: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue overfilled");

   // Once done, chunked beats give no result
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      b_status.pop && b_status.done && b_status.enable |=> !rsp.valid)
      else $error("result after terminal chunk");

endmodule

// File: src/hcd_front.sv
`timescale 1ns / 1ps

module hcd_front (
   hcd_req_if.sink               req,
   input  hcd_pkg::queue_status_type q_status,
   output hcd_pkg::push_type      push
);
   import hcd_pkg::*;

   logic ready;

   // Sort a byte into the classes the size line cares about
   function automatic beat_type classify(input logic [7:0] c);
      beat_type b;
      b.data     = c;
      b.is_lf    = (c == CHAR_LF);
      b.is_cr    = (c == CHAR_CR);
      b.is_blank = (c == CHAR_SP) || (c == CHAR_TAB);
      b.is_hex   = 1'b1;
      b.hex_val  = 4'd0;
      case (c) inside
         [8'h30:8'h39]: b.hex_val = c[3:0];
         [8'h41:8'h46],
         [8'h61:8'h66]: b.hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
         default:       b.is_hex = 1'b0;
      endcase
      return b;
   endfunction

   // Accept a beat whenever the queue has room
   assign ready      = !q_status.full;
   assign req.ready  = ready;
   assign push.valid = req.valid && ready;
   assign push.beat  = classify(req.in_byte);

endmodule

// File: src/hcd_queue.sv
`timescale 1ns / 1ps

module hcd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  hcd_pkg::push_type         push,
   input  logic                      pop,
   output hcd_pkg::beat_type         head,
   output hcd_pkg::queue_status_type status
);
   import hcd_pkg::*;

   beat_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.beat;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: src/hcd_back.sv
`timescale 1ns / 1ps

module hcd_back #(
   parameter int SIZE_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  hcd_pkg::queue_status_type q_status,
   input  hcd_pkg::beat_type         head,
   output logic                      pop,
   output hcd_pkg::back_status_type  status,
   hcd_rsp_if.source                 rsp
);
   import hcd_pkg::*;

   logic                  enable_ff;
   phase_type             phase_ff, phase_in;
   line_mode_type         line_mode_ff, line_mode_in;
   logic [SIZE_WIDTH-1:0] bytes_left_ff, bytes_left_in;
   logic [SIZE_WIDTH-1:0] size_accum_ff, size_accum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  stream_end_ff, stream_end_in;
   logic                  emit;

   // Take the head beat when the output register is free or drains this cycle
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp.ready);

   // Per-beat decode
   always_comb begin
      phase_in      = phase_ff;
      line_mode_in  = line_mode_ff;
      bytes_left_in = bytes_left_ff;
      size_accum_in = size_accum_ff;
      emit          = 1'b0;
      out_byte_in   = head.data;
      stream_end_in = 1'b0;
      if (pop) begin
         if (!enable_ff) begin
            emit = 1'b1;
         end else begin
            case (phase_ff)
               PH_SIZE: begin
                  if (head.is_lf) begin
                     size_accum_in = '0;
                     line_mode_in  = LM_LEAD;
                     if (size_accum_ff == '0) begin
                        phase_in      = PH_DONE;
                        emit          = 1'b1;
                        out_byte_in   = 8'd0;
                        stream_end_in = 1'b1;
                     end else begin
                        bytes_left_in = size_accum_ff;
                        phase_in      = PH_DATA;
                     end
                  end else if (head.is_cr) begin
                     line_mode_in = line_mode_ff;
                  end else if (line_mode_ff == LM_LEAD && head.is_blank) begin
                     line_mode_in = line_mode_ff;
                  end else if (line_mode_ff == LM_REST) begin
                     line_mode_in = line_mode_ff;
                  end else if (head.is_hex) begin
                     line_mode_in = LM_HEX;
                     // saturate once a further digit would overflow
                     if (size_accum_ff[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                        size_accum_in = '1;
                     end else begin
                        size_accum_in = {size_accum_ff[SIZE_WIDTH-5:0], head.hex_val};
                     end
                  end else begin
                     line_mode_in = LM_REST;
                  end
               end
               PH_DATA: begin
                  emit = 1'b1;
                  if (bytes_left_ff != '0) begin
                     bytes_left_in = bytes_left_ff - 1'b1;
                  end
                  if (bytes_left_ff <= SIZE_WIDTH'(1)) begin
                     phase_in = PH_CRLF;
                  end
               end
               PH_CRLF: begin
                  if (head.is_lf) begin
                     phase_in = PH_SIZE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // Load the output register on a result, drop valid when taken
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         phase_ff      <= PH_SIZE;
         line_mode_ff  <= LM_LEAD;
         bytes_left_ff <= '0;
         size_accum_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         phase_ff      <= phase_in;
         line_mode_ff  <= line_mode_in;
         bytes_left_ff <= bytes_left_in;
         size_accum_ff <= size_accum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold payload until the next result
   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff   <= out_byte_in;
         stream_end_ff <= stream_end_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = out_byte_ff;
   assign rsp.stream_end = stream_end_ff;

   assign status.pop    = pop;
   assign status.done   = (phase_ff == PH_DONE);
   assign status.enable = enable_ff;

endmodule
